// ===== design/seirbsp_pkg.sv =====
package seirbsp_pkg;

   localparam int MAX_TILES_DEF = 64;
   localparam int QUEUE_DEPTH   = 4;

   // Parse phases; a parsing phase number doubles as its element code.
   localparam logic [5:0] PH_TYPE        = 6'd0;
   localparam logic [5:0] PH_SIZE        = 6'd1;
   localparam logic [5:0] PH_PERSIST     = 6'd2;
   localparam logic [5:0] PH_RESET       = 6'd3;
   localparam logic [5:0] PH_INST_UPD    = 6'd4;
   localparam logic [5:0] PH_INST_IDX    = 6'd5;
   localparam logic [5:0] PH_INST_CANCEL = 6'd6;
   localparam logic [5:0] PH_METHOD      = 6'd7;
   localparam logic [5:0] PH_PBF_LOG2    = 6'd8;
   localparam logic [5:0] PH_PBF_PASSES  = 6'd9;
   localparam logic [5:0] PH_PBF_FSIZE   = 6'd10;
   localparam logic [5:0] PH_EOM_FLAG    = 6'd11;
   localparam logic [5:0] PH_GRID        = 6'd12;
   localparam logic [5:0] PH_THRESH      = 6'd13;
   localparam logic [5:0] PH_HCANCEL     = 6'd14;
   localparam logic [5:0] PH_HPERSIST    = 6'd15;
   localparam logic [5:0] PH_HTYPE       = 6'd16;
   localparam logic [5:0] PH_HFLAGS      = 6'd17;
   localparam logic [5:0] PH_HL_HASH     = 6'd18;
   localparam logic [5:0] PH_ATLAS_HASH  = 6'd19;
   localparam logic [5:0] PH_B2P_HASH    = 6'd20;
   localparam logic [5:0] PH_NUM_TILES   = 6'd21;
   localparam logic [5:0] PH_TID_LEN     = 6'd22;
   localparam logic [5:0] PH_TILE_ID     = 6'd23;
   localparam logic [5:0] PH_TILE_HASH   = 6'd24;
   localparam logic [5:0] PH_TILE_B2P    = 6'd25;
   localparam logic [5:0] PH_SKIP        = 6'd26;
   localparam logic [5:0] CODE_TRUNC     = 6'd27;
   localparam logic [5:0] PH_DISCARD     = 6'd28;
   localparam logic [5:0] PH_END         = 6'd63;

   localparam logic [15:0] TYPE_OCC    = 16'd65;
   localparam logic [15:0] TYPE_SMOOTH = 16'd66;
   localparam logic [15:0] TYPE_HASH   = 16'd19;
   localparam logic [7:0]  EXT_BYTE    = 8'hFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       suffix_unit;
      logic       final_byte;
   } byte_item_type;

   typedef struct packed {
      logic [4:0]  element_code;
      logic [31:0] element_value;
      logic [31:0] entry_id;
      logic [3:0]  byte_index;
      logic        message_done;
      logic        parse_error;
      logic        run_end;
   } result_type;

   function automatic logic is_golomb(input logic [5:0] p);
      return (p == PH_METHOD) || (p == PH_NUM_TILES) || (p == PH_TID_LEN);
   endfunction

   function automatic logic [5:0] hash_width(input logic [7:0] hk);
      return (hk == 8'd0) ? 6'd8 : ((hk == 8'd1) ? 6'd16 : 6'd32);
   endfunction

   function automatic logic [5:0] width_of(input logic [5:0] p, input logic [7:0] hk,
                                           input logic [5:0] tib);
      logic [5:0] w;
      case (p)
         PH_INST_UPD, PH_INST_IDX, PH_THRESH, PH_HTYPE: w = 6'd8;
         PH_PBF_LOG2, PH_PBF_PASSES: w = 6'd2;
         PH_PBF_FSIZE: w = 6'd3;
         PH_GRID: w = 6'd7;
         PH_HFLAGS: w = 6'd6;
         PH_HL_HASH, PH_ATLAS_HASH, PH_B2P_HASH, PH_TILE_HASH, PH_TILE_B2P:
            w = hash_width(hk);
         PH_TILE_ID: w = (tib != 6'd0) ? tib : 6'd1;
         default: w = 6'd1;
      endcase
      return w;
   endfunction

   function automatic logic [5:0] hash_next(input logic [5:0] from, input logic [4:0] hpf,
                                            input logic [7:0] hk);
      logic ok;
      logic [5:0] nx;
      ok = hk < 8'd3;
      if (from <= PH_HL_HASH && hpf[4] && ok) nx = PH_HL_HASH;
      else if (from <= PH_ATLAS_HASH && hpf[3] && ok) nx = PH_ATLAS_HASH;
      else if (from <= PH_B2P_HASH && hpf[2] && ok) nx = PH_B2P_HASH;
      else if (hpf[1] || hpf[0]) nx = PH_NUM_TILES;
      else nx = PH_END;
      return nx;
   endfunction

endpackage

// ===== design/seirbsp_req_if.sv =====
interface seirbsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       suffix_unit;
   logic       final_byte;

   modport source(output valid, data_byte, suffix_unit, final_byte, input ready);
   modport sink(input valid, data_byte, suffix_unit, final_byte, output ready);
endinterface

// ===== design/seirbsp_rsp_if.sv =====
interface seirbsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  element_code;
   logic [31:0] element_value;
   logic [31:0] entry_id;
   logic [3:0]  byte_index;
   logic        message_done;
   logic        parse_error;
   logic        run_end;

   modport source(output valid, element_code, element_value, entry_id, byte_index,
                  message_done, parse_error, run_end, input ready);
   modport sink(input valid, element_code, element_value, entry_id, byte_index,
                message_done, parse_error, run_end, output ready);
endinterface

// ===== design/seirbsp_byte_queue.sv =====
module seirbsp_byte_queue
   import seirbsp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   seirbsp_req_if.sink   req_chan,
   output byte_item_type q_item,
   output logic          q_valid,
   input  logic          q_pop
);
   localparam int PW = $clog2(QUEUE_DEPTH);

   byte_item_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]       wp_ff, rp_ff;
   logic [PW:0]         cnt_ff;
   logic                push;

   assign req_chan.ready = cnt_ff < (PW+1)'(QUEUE_DEPTH);
   assign push    = req_chan.valid && req_chan.ready;
   assign q_valid = cnt_ff != '0;
   assign q_item  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= '{data_byte: req_chan.data_byte, suffix_unit: req_chan.suffix_unit,
                            final_byte: req_chan.final_byte};
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (q_pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(q_pop);
      end
   end
endmodule

// ===== design/seirbsp_bit_engine.sv =====
module seirbsp_bit_engine
   import seirbsp_pkg::*;
#(
   parameter int MAX_TILES = MAX_TILES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  byte_item_type  q_item,
   input  logic           q_valid,
   output logic           q_pop,
   seirbsp_rsp_if.source  rsp_chan
);
   localparam int CNT_W = ((MAX_TILES + 1) > 256) ? $clog2(MAX_TILES + 1) : 8;
   localparam int IDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_BYTE  = 5'b00010,
      ST_BITS  = 5'b00100,
      ST_FIN   = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   // Closed form of the tile loop: next hash phase in this tile, else first one of the next.
   function automatic logic [6+CNT_W-1:0] tile_next(input logic [5:0] from,
         input logic [CNT_W-1:0] ci, input logic [CNT_W-1:0] tt, input logic [4:0] hpf,
         input logic [7:0] hk);
      logic ok;
      logic [CNT_W-1:0] cn;
      logic [5:0] nx;
      ok = hk < 8'd3;
      cn = ci;
      if (ok && from <= PH_TILE_HASH && hpf[1]) nx = PH_TILE_HASH;
      else if (ok && from <= PH_TILE_B2P && hpf[0]) nx = PH_TILE_B2P;
      else begin
         cn = ci + 1'b1;
         if (cn < tt && ok && (hpf[1] || hpf[0])) nx = hpf[1] ? PH_TILE_HASH : PH_TILE_B2P;
         else nx = PH_END;
      end
      return {nx, cn};
   endfunction

   state_type        st_ff, st_in;
   logic [7:0]       byte_ff, byte_in;
   logic             suf_ff, suf_in, fin_ff, fin_in;
   logic [3:0]       bit_ff, bit_in;
   logic [5:0]       phase_ff, phase_in;
   logic [31:0]      acc_ff, acc_in;
   logic [5:0]       need_ff, need_in, zc_ff, zc_in;
   logic [15:0]      tsum_ff, tsum_in, ssum_ff, ssum_in;
   logic [CNT_W-1:0] lc_ff, lc_in, ci_ff, ci_in, ttot_ff, ttot_in;
   logic [7:0]       itot_ff, itot_in, hk_ff, hk_in;
   logic [4:0]       hpf_ff, hpf_in;
   logic [5:0]       tib_ff, tib_in;
   result_type       hold_ff, hold_in, out_ff, out_in;
   logic             hold_v_ff, hold_v_in, out_v_ff, out_load;
   logic [31:0]      store [MAX_TILES];
   logic [31:0]      rd_ff;
   logic             we;
   logic [IDX_W-1:0] wa;
   logic [31:0]      wd;

   logic             go, emit_v, do_end, to_discard, complete, err, align, b;
   result_type       res;
   logic [3:0]       bl;
   logic [31:0]      accn, value, entry;
   logic [5:0]       needn, nx;
   logic [3:0]       bidx;
   logic [16:0]      sum17;
   logic [CNT_W-1:0] lcn;
   logic [6+CNT_W-1:0] tn;
   logic             occ, hsh;

   assign go = !out_v_ff || rsp_chan.ready;

   assign rsp_chan.valid         = out_v_ff;
   assign rsp_chan.element_code  = out_ff.element_code;
   assign rsp_chan.element_value = out_ff.element_value;
   assign rsp_chan.entry_id      = out_ff.entry_id;
   assign rsp_chan.byte_index    = out_ff.byte_index;
   assign rsp_chan.message_done  = out_ff.message_done;
   assign rsp_chan.parse_error   = out_ff.parse_error;
   assign rsp_chan.run_end       = out_ff.run_end;

   always_comb begin
      st_in = st_ff; byte_in = byte_ff; suf_in = suf_ff; fin_in = fin_ff; bit_in = bit_ff;
      phase_in = phase_ff; acc_in = acc_ff; need_in = need_ff; zc_in = zc_ff;
      tsum_in = tsum_ff; ssum_in = ssum_ff; lc_in = lc_ff; ci_in = ci_ff;
      ttot_in = ttot_ff; itot_in = itot_ff; hk_in = hk_ff; hpf_in = hpf_ff; tib_in = tib_ff;
      hold_in = hold_ff; hold_v_in = hold_v_ff; out_in = hold_ff; out_load = 1'b0;
      q_pop = 1'b0; emit_v = 1'b0; res = '0; do_end = 1'b0; to_discard = 1'b0;
      complete = 1'b0; err = 1'b0; align = 1'b0; value = '0; nx = PH_END;
      we = 1'b0; wa = '0; wd = '0; sum17 = '0; lcn = '0; tn = '0; occ = 1'b0; hsh = 1'b0;
      bl = bit_ff - 4'd1;
      b = byte_ff[bl[2:0]];
      accn = {acc_ff[30:0], b};
      needn = need_ff - 6'd1;
      entry = '0;
      bidx = '0;
      if (phase_ff == PH_INST_IDX || phase_ff == PH_TILE_ID) entry = 32'(lc_ff);
      else if (phase_ff >= PH_INST_CANCEL && phase_ff <= PH_THRESH) entry = 32'(ci_ff);
      else if (phase_ff == PH_TILE_HASH || phase_ff == PH_TILE_B2P) entry = rd_ff;
      if (((phase_ff >= PH_HL_HASH && phase_ff <= PH_B2P_HASH) || phase_ff == PH_TILE_HASH ||
           phase_ff == PH_TILE_B2P) && hk_ff == 8'd0) bidx = lc_ff[3:0];

      if (go) begin
         case (st_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  q_pop = 1'b1;
                  byte_in = q_item.data_byte;
                  suf_in = q_item.suffix_unit;
                  fin_in = q_item.final_byte;
                  st_in = ST_BYTE;
               end
            end
            ST_BYTE: begin
               st_in = ST_FIN;
               if (fin_ff && phase_ff == PH_TYPE && tsum_ff == 16'd0) begin
                  do_end = 1'b1;
               end else if (phase_ff == PH_TYPE) begin
                  sum17 = {1'b0, tsum_ff} + {9'd0, byte_ff};
                  tsum_in = sum17[16] ? 16'hFFFF : sum17[15:0];
                  if (byte_ff != EXT_BYTE) begin
                     emit_v = 1'b1;
                     res.element_code = PH_TYPE[4:0];
                     res.element_value = {16'd0, tsum_in};
                     phase_in = PH_SIZE;
                     ssum_in = '0;
                  end
               end else if (phase_ff == PH_SIZE) begin
                  sum17 = {1'b0, ssum_ff} + {9'd0, byte_ff};
                  ssum_in = sum17[16] ? 16'hFFFF : sum17[15:0];
                  if (byte_ff != EXT_BYTE) begin
                     occ = !suf_ff && (tsum_ff == TYPE_OCC || tsum_ff == TYPE_SMOOTH);
                     hsh = suf_ff && tsum_ff == TYPE_HASH;
                     emit_v = 1'b1;
                     res.element_code = PH_SIZE[4:0];
                     res.element_value = {16'd0, ssum_in};
                     if (occ || hsh) begin
                        phase_in = occ ? PH_PERSIST : PH_HCANCEL;
                        acc_in = '0;
                        zc_in = '0;
                        need_in = 6'd1;
                     end else if (ssum_in == 16'd0) begin
                        res.message_done = 1'b1;
                        do_end = 1'b1;
                     end else begin
                        phase_in = PH_SKIP;
                        acc_in = '0;
                     end
                  end
               end else if (phase_ff == PH_SKIP) begin
                  acc_in = acc_ff + 32'd1;
                  if (acc_in >= {16'd0, ssum_ff}) begin
                     emit_v = 1'b1;
                     res.element_code = PH_SKIP[4:0];
                     res.element_value = {16'd0, ssum_ff};
                     res.message_done = 1'b1;
                     do_end = 1'b1;
                  end
               end else if (phase_ff != PH_DISCARD) begin
                  bit_in = 4'd8;
                  st_in = ST_BITS;
               end
            end
            ST_BITS: begin
               bit_in = bl;
               st_in = (bl == 4'd0) ? ST_FIN : ST_BITS;
               if (is_golomb(phase_ff) && need_ff == 6'd0) begin
                  if (!b) begin
                     zc_in = zc_ff + 6'd1;
                     if (zc_in >= 6'd32) begin
                        emit_v = 1'b1;
                        res.element_code = phase_ff[4:0];
                        res.element_value = 32'hFFFFFFFF;
                        res.entry_id = entry;
                        res.message_done = 1'b1;
                        res.parse_error = 1'b1;
                        do_end = 1'b1;
                        to_discard = 1'b1;
                        st_in = ST_FIN;
                     end
                  end else if (zc_ff == 6'd0) begin
                     complete = 1'b1;
                  end else begin
                     need_in = zc_ff;
                     acc_in = '0;
                  end
               end else begin
                  acc_in = accn;
                  need_in = needn;
                  if (needn == 6'd0) begin
                     complete = 1'b1;
                     value = accn;
                     if (is_golomb(phase_ff))
                        value = 32'((33'd1 << zc_ff) - 33'd1) + accn;
                  end
               end
               if (complete) begin
                  case (phase_ff)
                     PH_PERSIST: nx = PH_RESET;
                     PH_RESET: nx = PH_INST_UPD;
                     PH_INST_UPD: begin
                        itot_in = value[7:0];
                        lc_in = '0;
                        nx = (value[7:0] != 8'd0) ? PH_INST_IDX : PH_END;
                     end
                     PH_INST_IDX: begin
                        ci_in = CNT_W'(value[7:0]);
                        nx = PH_INST_CANCEL;
                     end
                     PH_INST_CANCEL, PH_METHOD, PH_PBF_FSIZE, PH_THRESH: begin
                        lcn = lc_ff + 1'b1;
                        if (phase_ff == PH_INST_CANCEL && value == 32'd0) nx = PH_METHOD;
                        else if (phase_ff == PH_METHOD && tsum_ff == TYPE_OCC &&
                                 value != 32'd0) nx = PH_PBF_LOG2;
                        else if (phase_ff == PH_METHOD && tsum_ff != TYPE_OCC &&
                                 value == 32'd1) nx = PH_EOM_FLAG;
                        else begin
                           lc_in = lcn;
                           nx = (lcn < CNT_W'(itot_ff)) ? PH_INST_IDX : PH_END;
                        end
                     end
                     PH_PBF_LOG2: nx = PH_PBF_PASSES;
                     PH_PBF_PASSES: nx = PH_PBF_FSIZE;
                     PH_EOM_FLAG: nx = PH_GRID;
                     PH_GRID: nx = PH_THRESH;
                     PH_HCANCEL: nx = (value != 32'd0) ? PH_END : PH_HPERSIST;
                     PH_HPERSIST: nx = PH_HTYPE;
                     PH_HTYPE: begin
                        hk_in = value[7:0];
                        nx = PH_HFLAGS;
                     end
                     PH_HFLAGS: begin
                        hpf_in = value[5:1];
                        lc_in = '0;
                        nx = hash_next(PH_HL_HASH, value[5:1], hk_ff);
                     end
                     PH_HL_HASH, PH_ATLAS_HASH, PH_B2P_HASH: begin
                        lcn = lc_ff + 1'b1;
                        if (hk_ff == 8'd0 && lcn < CNT_W'(16)) begin
                           lc_in = lcn;
                           nx = phase_ff;
                        end else begin
                           lc_in = '0;
                           nx = hash_next(phase_ff + 6'd1, hpf_ff, hk_ff);
                        end
                     end
                     PH_NUM_TILES: begin
                        if (value >= 32'(MAX_TILES)) begin
                           ttot_in = CNT_W'(MAX_TILES);
                           err = 1'b1;
                        end else ttot_in = CNT_W'(value + 32'd1);
                        nx = PH_TID_LEN;
                     end
                     PH_TID_LEN: begin
                        if (value >= 32'd32) begin
                           tib_in = 6'd32;
                           err = 1'b1;
                        end else tib_in = 6'(value + 32'd1);
                        lc_in = '0;
                        nx = PH_TILE_ID;
                     end
                     PH_TILE_ID: begin
                        we = 1'b1;
                        wa = lc_ff[IDX_W-1:0];
                        wd = value;
                        lcn = lc_ff + 1'b1;
                        if (lcn < ttot_ff) begin
                           lc_in = lcn;
                           nx = PH_TILE_ID;
                        end else begin
                           align = 1'b1;
                           lc_in = '0;
                           tn = tile_next(PH_TILE_HASH, '0, ttot_ff, hpf_ff, hk_ff);
                           ci_in = tn[CNT_W-1:0];
                           nx = tn[6+CNT_W-1:CNT_W];
                        end
                     end
                     PH_TILE_HASH, PH_TILE_B2P: begin
                        lcn = lc_ff + 1'b1;
                        if (hk_ff == 8'd0 && lcn < CNT_W'(16)) begin
                           lc_in = lcn;
                           nx = phase_ff;
                        end else begin
                           lc_in = '0;
                           tn = tile_next(phase_ff + 6'd1, ci_ff, ttot_ff, hpf_ff, hk_ff);
                           ci_in = tn[CNT_W-1:0];
                           nx = tn[6+CNT_W-1:CNT_W];
                        end
                     end
                     default: nx = PH_END;
                  endcase
                  emit_v = 1'b1;
                  res.element_code = phase_ff[4:0];
                  res.element_value = value;
                  res.entry_id = entry;
                  res.byte_index = bidx;
                  res.message_done = nx == PH_END;
                  res.parse_error = err;
                  if (nx == PH_END) begin
                     do_end = 1'b1;
                     st_in = ST_FIN;
                  end else begin
                     phase_in = nx;
                     acc_in = '0;
                     zc_in = '0;
                     need_in = is_golomb(nx) ? 6'd0 : width_of(nx, hk_in, tib_in);
                     if (align) st_in = ST_FIN;
                  end
               end
            end
            ST_FIN: begin
               st_in = ST_FLUSH;
               if (fin_ff) begin
                  if (phase_ff == PH_DISCARD) do_end = 1'b1;
                  else if (!(phase_ff == PH_TYPE && tsum_ff == 16'd0)) begin
                     emit_v = 1'b1;
                     res.element_code = CODE_TRUNC[4:0];
                     res.message_done = 1'b1;
                     res.parse_error = 1'b1;
                     do_end = 1'b1;
                  end
               end
            end
            ST_FLUSH: begin
               st_in = ST_IDLE;
               if (hold_v_ff) begin
                  out_load = 1'b1;
                  out_in.run_end = 1'b1;
                  hold_v_in = 1'b0;
               end
            end
            default: st_in = ST_IDLE;
         endcase
         if (emit_v) begin
            if (hold_v_ff) out_load = 1'b1;
            hold_in = res;
            hold_v_in = 1'b1;
         end
         if (do_end) begin
            phase_in = PH_TYPE;
            tsum_in = '0;
            ssum_in = '0;
            acc_in = '0;
            need_in = '0;
            zc_in = '0;
         end
         if (to_discard) phase_in = PH_DISCARD;
      end
   end

   always_ff @(posedge clock) begin
      if (we) store[wa] <= wd;
      rd_ff <= store[ci_ff[IDX_W-1:0]];
      byte_ff <= byte_in;
      suf_ff <= suf_in;
      fin_ff <= fin_in;
      hold_ff <= hold_in;
      if (out_load) out_ff <= out_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         bit_ff <= '0;
         phase_ff <= PH_TYPE;
         acc_ff <= '0;
         need_ff <= '0;
         zc_ff <= '0;
         tsum_ff <= '0;
         ssum_ff <= '0;
         lc_ff <= '0;
         ci_ff <= '0;
         ttot_ff <= '0;
         itot_ff <= '0;
         hk_ff <= '0;
         hpf_ff <= '0;
         tib_ff <= '0;
         hold_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         bit_ff <= bit_in;
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         need_ff <= need_in;
         zc_ff <= zc_in;
         tsum_ff <= tsum_in;
         ssum_ff <= ssum_in;
         lc_ff <= lc_in;
         ci_ff <= ci_in;
         ttot_ff <= ttot_in;
         itot_ff <= itot_in;
         hk_ff <= hk_in;
         hpf_ff <= hpf_in;
         tib_ff <= tib_in;
         hold_v_ff <= hold_v_in;
         if (out_load) out_v_ff <= 1'b1;
         else if (rsp_chan.ready) out_v_ff <= 1'b0;
      end
   end
endmodule

// ===== design/sei_rbsp_syntax_parser.sv =====
// Each byte goes through the engine states in order: idle (taken from the queue), byte
// (header work), one bit step per bit it parses (up to eight), then the final-byte mark
// and the flush of its last result. The engine works on one byte at a time, and every
// step waits while the output register holds a result that has not been taken.
// Reset is synchronous and active high; it empties the byte queue and returns the parser
// to the message header with all counters cleared. The tile id store is not cleared.
module sei_rbsp_syntax_parser
   import seirbsp_pkg::*;
#(
   parameter int MAX_TILES = MAX_TILES_DEF
) (
   input logic            clock,
   input logic            reset,
   seirbsp_req_if.sink    req_chan,
   seirbsp_rsp_if.source  rsp_chan
);
   // The front queue takes a transfer whenever it has room, so the sender is not
   // held up while the engine works through the bits of the previous byte.
   byte_item_type q_item;
   logic          q_valid;
   logic          q_pop;

   seirbsp_byte_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop)
   );

   // The engine holds each element back by one so that it can mark the last element
   // caused by a byte, then moves it into the output register for transfer.
   seirbsp_bit_engine #(
      .MAX_TILES (MAX_TILES)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );
endmodule
